// ===== design/lorenz_pkg.sv =====
// Shared types, constants and the microcode table of the Lorenz Euler stepper.
// No dependencies; used by lorenz_euler_step and the verification files.
package lorenz_pkg;

    localparam int STATE_WIDTH = 32;
    localparam int FRAC_BITS   = 24;

    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DT_W       = 24;
    localparam int COEF_W     = 31;
    localparam int START_W    = 32;
    localparam int UPC_W      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RHO       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z   = 3'd6;

    localparam logic [DT_W-1:0]    RST_DT    = 24'd167772;
    localparam logic [COEF_W-1:0]  RST_SIGMA = 31'd167772160;
    localparam logic [COEF_W-1:0]  RST_RHO   = 31'd469762048;
    localparam logic [COEF_W-1:0]  RST_BETA  = 31'd44739243;
    localparam logic [START_W-1:0] RST_START = 32'd16777216;

    typedef logic [2:0]       t_op;
    typedef logic [3:0]       t_sel;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_op OP_JNR = 3'd0;  // jump when no restart
    localparam t_op OP_LDS = 3'd1;  // load start point
    localparam t_op OP_SUB = 3'd2;
    localparam t_op OP_ADD = 3'd3;
    localparam t_op OP_MUL = 3'd4;
    localparam t_op OP_END = 3'd5;

    localparam t_sel SEL_X  = 4'd0;
    localparam t_sel SEL_Y  = 4'd1;
    localparam t_sel SEL_Z  = 4'd2;
    localparam t_sel SEL_T0 = 4'd3;
    localparam t_sel SEL_T1 = 4'd4;
    localparam t_sel SEL_T2 = 4'd5;
    localparam t_sel SEL_T3 = 4'd6;
    localparam t_sel SEL_SG = 4'd7;
    localparam t_sel SEL_RH = 4'd8;
    localparam t_sel SEL_BT = 4'd9;
    localparam t_sel SEL_DT = 4'd10;

    localparam t_upc UPC_CALC = 5'd2;

    typedef struct packed {
        t_op  op;
        t_sel dst;
        t_sel sa;
        t_sel sb;
        t_upc tgt;
    } t_uword;

    function automatic t_uword f_ucode(input t_upc pc);
        t_uword w;
        case (pc)
            5'd0:  w = '{OP_JNR, SEL_X,  SEL_X,  SEL_X,  UPC_CALC};
            5'd1:  w = '{OP_LDS, SEL_X,  SEL_X,  SEL_X,  UPC_CALC};
            5'd2:  w = '{OP_SUB, SEL_T0, SEL_Y,  SEL_X,  UPC_CALC};
            5'd3:  w = '{OP_MUL, SEL_T0, SEL_SG, SEL_T0, UPC_CALC};
            5'd4:  w = '{OP_SUB, SEL_T1, SEL_RH, SEL_Z,  UPC_CALC};
            5'd5:  w = '{OP_MUL, SEL_T1, SEL_X,  SEL_T1, UPC_CALC};
            5'd6:  w = '{OP_SUB, SEL_T1, SEL_T1, SEL_Y,  UPC_CALC};
            5'd7:  w = '{OP_MUL, SEL_T2, SEL_X,  SEL_Y,  UPC_CALC};
            5'd8:  w = '{OP_MUL, SEL_T3, SEL_BT, SEL_Z,  UPC_CALC};
            5'd9:  w = '{OP_SUB, SEL_T2, SEL_T2, SEL_T3, UPC_CALC};
            5'd10: w = '{OP_MUL, SEL_T0, SEL_T0, SEL_DT, UPC_CALC};
            5'd11: w = '{OP_MUL, SEL_T1, SEL_T1, SEL_DT, UPC_CALC};
            5'd12: w = '{OP_MUL, SEL_T2, SEL_T2, SEL_DT, UPC_CALC};
            5'd13: w = '{OP_ADD, SEL_X,  SEL_X,  SEL_T0, UPC_CALC};
            5'd14: w = '{OP_ADD, SEL_Y,  SEL_Y,  SEL_T1, UPC_CALC};
            5'd15: w = '{OP_ADD, SEL_Z,  SEL_Z,  SEL_T2, UPC_CALC};
            default: w = '{OP_END, SEL_X, SEL_X, SEL_X, UPC_CALC};
        endcase
        return w;
    endfunction

endpackage

// ===== design/lorenz_in_if.sv =====
// Input channel of the Lorenz Euler stepper: valid/ready plus step flags.
// No dependencies.
interface lorenz_in_if;
    logic valid;
    logic ready;
    logic restart;
    logic last_step;

    modport source (output valid, output restart, output last_step, input ready);
    modport sink   (input valid, input restart, input last_step, output ready);
endinterface

// ===== design/lorenz_out_if.sv =====
// Output channel of the Lorenz Euler stepper: valid/ready plus the new point.
// No dependencies.
interface lorenz_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               run_end;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output run_end, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input run_end, output ready);
endinterface

// ===== design/lorenz_fxmul.sv =====
// Multi-cycle saturating signed fixed-point multiplier, 32x32 partial products.
// No package dependencies; instantiated by lorenz_euler_step.
module lorenz_fxmul #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_p
);

    localparam int CH  = 32;
    localparam int NCH = (W + CH - 1) / CH;
    localparam int MW  = NCH * CH;
    localparam int PW  = 2 * MW;
    localparam int IW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PSW = $clog2(2 * NCH) + 1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_ACC  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    localparam logic [W-1:0]  SMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  SMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [IW-1:0] ILAST  = IW'(NCH - 1);

    logic [1:0]      r_ph;
    logic [MW-1:0]   r_ma, r_mb;
    logic            r_neg;
    logic [PW-1:0]   r_acc;
    logic [2*CH-1:0] r_pp;
    logic [PSW-1:0]  r_ps;
    logic [IW-1:0]   r_ia, r_ib;
    logic            r_last;
    logic            r_done;
    logic [W-1:0]    r_p;

    logic [W-1:0]    a_mag, b_mag;
    logic [2*CH-1:0] pp_next;
    logic [PW-1:0]   m_shr, lim;
    logic [W-1:0]    p_sat;

    always_comb begin
        a_mag   = i_a[W-1] ? (~i_a + 1'b1) : i_a;
        b_mag   = i_b[W-1] ? (~i_b + 1'b1) : i_b;
        pp_next = (2*CH)'(r_ma[r_ia*CH +: CH]) * (2*CH)'(r_mb[r_ib*CH +: CH]);
        m_shr   = r_acc >> F;
        lim     = PW'(SMAX_W) + PW'(r_neg);
        if (m_shr > lim) begin
            p_sat = r_neg ? SMIN_W : SMAX_W;
        end else if (r_neg) begin
            p_sat = ~m_shr[W-1:0] + 1'b1;
        end else begin
            p_sat = m_shr[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_ma  <= MW'(a_mag);
                        r_mb  <= MW'(b_mag);
                        r_neg <= i_a[W-1] ^ i_b[W-1];
                        r_acc <= '0;
                        r_ia  <= '0;
                        r_ib  <= '0;
                        r_ph  <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_pp   <= pp_next;
                    r_ps   <= PSW'(r_ia) + PSW'(r_ib);
                    r_last <= (r_ia == ILAST) && (r_ib == ILAST);
                    if (r_ib == ILAST) begin
                        r_ib <= '0;
                        r_ia <= r_ia + 1'b1;
                    end else begin
                        r_ib <= r_ib + 1'b1;
                    end
                    r_ph <= PH_ACC;
                end
                PH_ACC: begin
                    r_acc <= r_acc + (PW'(r_pp) << (r_ps * CH));
                    r_ph  <= r_last ? PH_FIN : PH_MUL;
                end
                PH_FIN: begin
                    r_p    <= p_sat;
                    r_done <= 1'b1;
                    r_ph   <= PH_IDLE;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== design/lorenz_euler_step.sv =====
// Lorenz system forward-Euler stepper: each input word advances (x, y, z) by one
// step in signed fixed point and returns the new point. One item is worked at a
// time by a microcoded sequencer over a shared multiplier; a set restart flag first
// reloads the start point. The seven multiplies on the shared multiplier take most
// of the time of an item. A finished point waits in the output register while the
// next item runs.
// Depends on lorenz_pkg, lorenz_in_if, lorenz_out_if and lorenz_fxmul.
module lorenz_euler_step #(
    parameter int STATE_WIDTH = lorenz_pkg::STATE_WIDTH,
    parameter int FRAC_BITS   = lorenz_pkg::FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lorenz_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lorenz_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lorenz_in_if.sink                          i_step,
    lorenz_out_if.source                       o_pos
);

    localparam int W  = STATE_WIDTH;
    localparam int XW = ((W > lorenz_pkg::START_W) ? W : lorenz_pkg::START_W) + 1;

    localparam logic signed [XW-1:0] SMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W:0]    SMAX_E = {2'b00, {(W-1){1'b1}}};
    localparam logic signed [W:0]    SMIN_E = {2'b11, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] f_clamp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        c = (v > SMAX_X) ? SMAX_X : ((v < SMIN_X) ? SMIN_X : v);
        return c[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] f_from_s32(
        input logic signed [lorenz_pkg::START_W-1:0] v);
        return f_clamp(XW'(v));
    endfunction

    function automatic logic signed [W-1:0] f_from_u31(
        input logic [lorenz_pkg::COEF_W-1:0] v);
        return f_clamp($signed(XW'(v)));
    endfunction

    function automatic logic [lorenz_pkg::POS_W-1:0] f_low32(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        e = XW'(v);
        return e[lorenz_pkg::POS_W-1:0];
    endfunction

    localparam logic signed [W-1:0] RST_POINT =
        f_from_s32($signed(lorenz_pkg::RST_START));

    // configuration
    logic [lorenz_pkg::DT_W-1:0]           r_dt;
    logic [lorenz_pkg::COEF_W-1:0]         r_sg, r_rh, r_bt;
    logic signed [lorenz_pkg::START_W-1:0] r_sx, r_sy, r_sz;

    // sequencer
    logic                   r_busy;
    lorenz_pkg::t_upc       r_pc;
    logic                   r_restart, r_last;
    logic                   r_mwait;

    // datapath
    logic signed [W-1:0]    r_x, r_y, r_z, r_t0, r_t1, r_t2, r_t3;

    // output register
    logic                   r_ov;
    logic [lorenz_pkg::POS_W-1:0] r_px, r_py, r_pz;
    logic                   r_pend;

    lorenz_pkg::t_uword     uw;
    logic signed [W-1:0]    opa, opb;
    logic signed [W:0]      sum;
    logic signed [W-1:0]    alu_sat;
    logic signed [W-1:0]    n_wb;
    logic                   wb_en;
    logic                   mul_start, mul_done;
    logic signed [W-1:0]    mul_p;
    logic                   in_acc, out_free, out_load;

    function automatic logic signed [W-1:0] f_pick(input lorenz_pkg::t_sel s,
        input logic signed [W-1:0] x, input logic signed [W-1:0] y,
        input logic signed [W-1:0] z, input logic signed [W-1:0] t0,
        input logic signed [W-1:0] t1, input logic signed [W-1:0] t2,
        input logic signed [W-1:0] t3, input logic signed [W-1:0] sg,
        input logic signed [W-1:0] rh, input logic signed [W-1:0] bt,
        input logic signed [W-1:0] dt);
        logic signed [W-1:0] r;
        case (s)
            lorenz_pkg::SEL_X:  r = x;
            lorenz_pkg::SEL_Y:  r = y;
            lorenz_pkg::SEL_Z:  r = z;
            lorenz_pkg::SEL_T0: r = t0;
            lorenz_pkg::SEL_T1: r = t1;
            lorenz_pkg::SEL_T2: r = t2;
            lorenz_pkg::SEL_T3: r = t3;
            lorenz_pkg::SEL_SG: r = sg;
            lorenz_pkg::SEL_RH: r = rh;
            lorenz_pkg::SEL_BT: r = bt;
            lorenz_pkg::SEL_DT: r = dt;
            default:            r = '0;
        endcase
        return r;
    endfunction

    logic signed [W-1:0] c_sg, c_rh, c_bt, c_dt;

    always_comb begin
        uw   = lorenz_pkg::f_ucode(r_pc);
        c_sg = f_from_u31(r_sg);
        c_rh = f_from_u31(r_rh);
        c_bt = f_from_u31(r_bt);
        c_dt = f_from_u31(lorenz_pkg::COEF_W'(r_dt));
        opa  = f_pick(uw.sa, r_x, r_y, r_z, r_t0, r_t1, r_t2, r_t3, c_sg, c_rh, c_bt, c_dt);
        opb  = f_pick(uw.sb, r_x, r_y, r_z, r_t0, r_t1, r_t2, r_t3, c_sg, c_rh, c_bt, c_dt);
        if (uw.op == lorenz_pkg::OP_SUB) begin
            sum = {opa[W-1], opa} - {opb[W-1], opb};
        end else begin
            sum = {opa[W-1], opa} + {opb[W-1], opb};
        end
        if (sum > SMAX_E) begin
            alu_sat = SMAX_E[W-1:0];
        end else if (sum < SMIN_E) begin
            alu_sat = SMIN_E[W-1:0];
        end else begin
            alu_sat = sum[W-1:0];
        end
        n_wb  = (uw.op == lorenz_pkg::OP_MUL) ? mul_p : alu_sat;
        wb_en = r_busy && ((uw.op == lorenz_pkg::OP_SUB) || (uw.op == lorenz_pkg::OP_ADD) ||
                           ((uw.op == lorenz_pkg::OP_MUL) && r_mwait && mul_done));
    end

    assign mul_start = r_busy && (uw.op == lorenz_pkg::OP_MUL) && !r_mwait;
    assign in_acc    = i_step.valid && !r_busy;
    assign out_free  = !r_ov || o_pos.ready;
    assign out_load  = r_busy && (uw.op == lorenz_pkg::OP_END) && out_free;

    lorenz_fxmul #(
        .W (W),
        .F (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= lorenz_pkg::RST_DT;
            r_sg    <= lorenz_pkg::RST_SIGMA;
            r_rh    <= lorenz_pkg::RST_RHO;
            r_bt    <= lorenz_pkg::RST_BETA;
            r_sx    <= lorenz_pkg::RST_START;
            r_sy    <= lorenz_pkg::RST_START;
            r_sz    <= lorenz_pkg::RST_START;
            r_x     <= RST_POINT;
            r_y     <= RST_POINT;
            r_z     <= RST_POINT;
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_mwait <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lorenz_pkg::REG_STEP_SIZE: r_dt <= i_cfg_data[lorenz_pkg::DT_W-1:0];
                    lorenz_pkg::REG_SIGMA:     r_sg <= i_cfg_data[lorenz_pkg::COEF_W-1:0];
                    lorenz_pkg::REG_RHO:       r_rh <= i_cfg_data[lorenz_pkg::COEF_W-1:0];
                    lorenz_pkg::REG_BETA:      r_bt <= i_cfg_data[lorenz_pkg::COEF_W-1:0];
                    lorenz_pkg::REG_START_X:   r_sx <= i_cfg_data;
                    lorenz_pkg::REG_START_Y:   r_sy <= i_cfg_data;
                    lorenz_pkg::REG_START_Z:   r_sz <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_ov && o_pos.ready && !out_load) begin
                r_ov <= 1'b0;
            end

            if (in_acc) begin
                r_busy    <= 1'b1;
                r_pc      <= '0;
                r_restart <= i_step.restart;
                r_last    <= i_step.last_step;
            end

            if (wb_en) begin
                case (uw.dst)
                    lorenz_pkg::SEL_X:  r_x  <= n_wb;
                    lorenz_pkg::SEL_Y:  r_y  <= n_wb;
                    lorenz_pkg::SEL_Z:  r_z  <= n_wb;
                    lorenz_pkg::SEL_T0: r_t0 <= n_wb;
                    lorenz_pkg::SEL_T1: r_t1 <= n_wb;
                    lorenz_pkg::SEL_T2: r_t2 <= n_wb;
                    lorenz_pkg::SEL_T3: r_t3 <= n_wb;
                    default: ;
                endcase
            end

            if (r_busy) begin
                case (uw.op)
                    lorenz_pkg::OP_JNR: begin
                        r_pc <= r_restart ? r_pc + 1'b1 : uw.tgt;
                    end
                    lorenz_pkg::OP_LDS: begin
                        r_x  <= f_from_s32(r_sx);
                        r_y  <= f_from_s32(r_sy);
                        r_z  <= f_from_s32(r_sz);
                        r_pc <= r_pc + 1'b1;
                    end
                    lorenz_pkg::OP_SUB, lorenz_pkg::OP_ADD: begin
                        r_pc <= r_pc + 1'b1;
                    end
                    lorenz_pkg::OP_MUL: begin
                        if (!r_mwait) begin
                            r_mwait <= 1'b1;
                        end else if (mul_done) begin
                            r_mwait <= 1'b0;
                            r_pc    <= r_pc + 1'b1;
                        end
                    end
                    lorenz_pkg::OP_END: begin
                        if (out_free) begin
                            r_ov   <= 1'b1;
                            r_px   <= f_low32(r_x);
                            r_py   <= f_low32(r_y);
                            r_pz   <= f_low32(r_z);
                            r_pend <= r_last;
                            r_busy <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign i_step.ready  = !r_busy;
    assign o_pos.valid   = r_ov;
    assign o_pos.pos_x   = r_px;
    assign o_pos.pos_y   = r_py;
    assign o_pos.pos_z   = r_pz;
    assign o_pos.run_end = r_pend;

endmodule

// ===== design/lorenz_checker.sv =====
// Port-level assertions for lorenz_euler_step, attached by the bind below.
// Depends on lorenz_euler_step and its channel interfaces.
module lorenz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_pos_x,
    input logic [31:0] i_pos_y,
    input logic [31:0] i_pos_z,
    input logic        i_run_end
);

    logic [1:0] r_pend;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // words taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("not idle after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken while a step is running");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || r_pend != 2'd0) && r_pend != 2'd3)
        else $error("output count does not match input count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pos_x) &&
        $stable(i_pos_y) && $stable(i_pos_z) && $stable(i_run_end))
        else $error("stalled output word changed");

endmodule

bind lorenz_euler_step lorenz_checker u_lorenz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_step.valid),
    .i_in_ready  (i_step.ready),
    .i_out_valid (o_pos.valid),
    .i_out_ready (o_pos.ready),
    .i_pos_x     (o_pos.pos_x),
    .i_pos_y     (o_pos.pos_y),
    .i_pos_z     (o_pos.pos_z),
    .i_run_end   (o_pos.run_end)
);

// ===== verif/lorenz_step_check_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Lorenz Euler stepper test: a saturating fixed-point model of
// one Euler step, its own register copy, and the queue of expected output words.
// Depends on lorenz_pkg.
package lorenz_step_check_pkg;
    import lorenz_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam longint SAT_HI = (longint'(1) << (STATE_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic             run_end;
    } t_point;

    class euler_point_scoreboard;
        logic [DT_W-1:0]    step_size;
        logic [COEF_W-1:0]  sigma;
        logic [COEF_W-1:0]  rho;
        logic [COEF_W-1:0]  beta;
        logic [START_W-1:0] start_x;
        logic [START_W-1:0] start_y;
        logic [START_W-1:0] start_z;
        longint             cur_x;
        longint             cur_y;
        longint             cur_z;
        t_point             pending_points[$];
        int                 mismatch_count;

        function new();
            step_size      = RST_DT;
            sigma          = RST_SIGMA;
            rho            = RST_RHO;
            beta           = RST_BETA;
            start_x        = RST_START;
            start_y        = RST_START;
            start_z        = RST_START;
            cur_x          = $signed(start_x);
            cur_y          = $signed(start_y);
            cur_z          = $signed(start_z);
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEP_SIZE: step_size = data[DT_W-1:0];
                REG_SIGMA:     sigma     = data[COEF_W-1:0];
                REG_RHO:       rho       = data[COEF_W-1:0];
                REG_BETA:      beta      = data[COEF_W-1:0];
                REG_START_X:   start_x   = data[START_W-1:0];
                REG_START_Y:   start_y   = data[START_W-1:0];
                REG_START_Z:   start_z   = data[START_W-1:0];
                default: ;
            endcase
        endfunction

        function longint saturate(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        // magnitude product, truncated toward zero, then saturated
        function longint fx_product(longint a, longint b);
            logic        neg;
            logic [63:0] ua;
            logic [63:0] ub;
            logic [63:0] mag;
            logic [63:0] lim;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            mag = (ua * ub) >> FRAC_BITS;
            lim = 64'(SAT_HI) + 64'(neg);
            if (mag > lim) return neg ? SAT_LO : SAT_HI;
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function void note_step(logic restart, logic last_step);
            longint x, y, z, dt, dx, dy, dz;
            t_point p;
            if (restart) begin
                cur_x = $signed(start_x);
                cur_y = $signed(start_y);
                cur_z = $signed(start_z);
            end
            x  = cur_x;
            y  = cur_y;
            z  = cur_z;
            dt = longint'(step_size);
            dx = fx_product(longint'(sigma), saturate(y - x));
            dy = saturate(fx_product(x, saturate(longint'(rho) - z)) - y);
            dz = saturate(fx_product(x, y) - fx_product(longint'(beta), z));
            cur_x = saturate(x + fx_product(dx, dt));
            cur_y = saturate(y + fx_product(dy, dt));
            cur_z = saturate(z + fx_product(dz, dt));
            p.pos_x   = cur_x[POS_W-1:0];
            p.pos_y   = cur_y[POS_W-1:0];
            p.pos_z   = cur_z[POS_W-1:0];
            p.run_end = last_step;
            pending_points.push_back(p);
        endfunction

        function void check_point(logic [POS_W-1:0] got_x, logic [POS_W-1:0] got_y,
                                  logic [POS_W-1:0] got_z, logic got_end);
            t_point want;
            if (pending_points.size() == 0) begin
                $error("output word with no step pending");
                mismatch_count++;
                return;
            end
            want = pending_points.pop_front();
            if (got_x !== want.pos_x) begin
                $error("pos_x: expected %h, got %h", want.pos_x, got_x);
                mismatch_count++;
            end
            if (got_y !== want.pos_y) begin
                $error("pos_y: expected %h, got %h", want.pos_y, got_y);
                mismatch_count++;
            end
            if (got_z !== want.pos_z) begin
                $error("pos_z: expected %h, got %h", want.pos_z, got_z);
                mismatch_count++;
            end
            if (got_end !== want.run_end) begin
                $error("run_end: expected %b, got %b", want.run_end, got_end);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass

endpackage

// ===== verif/lorenz_euler_step_test.sv =====
`timescale 1ns / 1ps
// Top of the Lorenz Euler stepper test: clock, reset, register phases, step words
// sent in bursts, a stalling output side and a cycle watchdog.
// Depends on lorenz_pkg, lorenz_step_check_pkg, the channel interfaces and the design.
module lorenz_euler_step_test;
    import lorenz_pkg::*;
    import lorenz_step_check_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 12;
    localparam int RANDOM_ITEMS = 1930;

    typedef struct {
        logic [DT_W-1:0]    dt;
        logic [COEF_W-1:0]  sigma;
        logic [COEF_W-1:0]  rho;
        logic [COEF_W-1:0]  beta;
        logic [START_W-1:0] sx;
        logic [START_W-1:0] sy;
        logic [START_W-1:0] sz;
    } t_setting;

    typedef enum {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_COIN} t_rx_mode;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    bit                    hold_req = 1'b0;
    int                    idle_cycles = 0;
    euler_point_scoreboard board;

    lorenz_in_if  step_ch ();
    lorenz_out_if pos_ch ();

    lorenz_euler_step uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_step     (step_ch),
        .o_pos      (pos_ch)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && pos_ch.valid && pos_ch.ready)
            board.check_point(pos_ch.pos_x, pos_ch.pos_y, pos_ch.pos_z, pos_ch.run_end);
        if ((step_ch.valid && step_ch.ready) || (pos_ch.valid && pos_ch.ready) || cfg_we) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // output side: stall patterns, plus one long hold-off on request
    initial begin
        t_rx_mode mode;
        int       span;
        int       beat;
        pos_ch.ready = 1'b0;
        mode = RX_OPEN;
        span = 0;
        beat = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pos_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    span = $urandom_range(20, 300);
                end
                span--;
                beat++;
                case (mode)
                    RX_OPEN:     pos_ch.ready <= 1'b1;
                    RX_MOSTLY:   pos_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: pos_ch.ready <= (beat % 5 < 2);
                    default:     pos_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    task automatic send_step(input logic restart, input logic last_step);
        step_ch.valid     <= 1'b1;
        step_ch.restart   <= restart;
        step_ch.last_step <= last_step;
        do @(posedge i_clk); while (!step_ch.ready);
        board.note_step(restart, last_step);
        @(negedge i_clk);
    endtask

    task automatic drain();
        step_ch.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_word(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        board.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // unused upper bits carry junk; an out-of-range index write ends each batch
    task automatic apply_setting(input t_setting s);
        logic [31:0] junk;
        junk = $urandom();
        write_word(REG_STEP_SIZE, {junk[31:24], s.dt});
        write_word(REG_SIGMA, {junk[23], s.sigma});
        write_word(REG_RHO, {junk[22], s.rho});
        write_word(REG_BETA, {junk[21], s.beta});
        write_word(REG_START_X, s.sx);
        write_word(REG_START_Y, s.sy);
        write_word(REG_START_Z, s.sz);
        write_word(REG_NONE, $urandom());
        cfg_we <= 1'b0;
    endtask

    function automatic t_setting random_setting(input bit tame);
        t_setting s;
        if (tame) begin
            s.dt    = DT_W'($urandom_range(0, 1 << 19));
            s.sigma = COEF_W'($urandom_range(0, 20 << 24));
            s.rho   = COEF_W'($urandom_range(0, 50 << 24));
            s.beta  = COEF_W'($urandom_range(0, 8 << 24));
            s.sx    = 32'($urandom_range(0, 60 << 24)) - 32'(30 << 24);
            s.sy    = 32'($urandom_range(0, 60 << 24)) - 32'(30 << 24);
            s.sz    = 32'($urandom_range(0, 60 << 24)) - 32'(30 << 24);
        end else begin
            s.dt    = DT_W'($urandom());
            s.sigma = COEF_W'($urandom());
            s.rho   = COEF_W'($urandom());
            s.beta  = COEF_W'($urandom());
            s.sx    = $urandom();
            s.sy    = $urandom();
            s.sz    = $urandom();
        end
        return s;
    endfunction

    initial begin
        t_setting s;
        int       left;
        int       n;
        int       sent;
        int       burst;
        int       phase;
        bit       gapless;
        board = new();
        step_ch.valid     = 1'b0;
        step_ch.restart   = 1'b0;
        step_ch.last_step = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset point and restart flags
        send_step(1'b0, 1'b0);
        send_step(1'b0, 1'b1);
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        drain();

        // largest coefficients and dt, start point on the rails
        s = '{24'hffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
              32'h7fffffff, 32'h80000000, 32'h7fffffff};
        apply_setting(s);
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        send_step(1'b0, 1'b1);
        send_step(1'b1, 1'b1);
        drain();

        // all zero, lowest start point
        s = '{24'h0, 31'h0, 31'h0, 31'h0, 32'h80000000, 32'h80000000, 32'h80000000};
        apply_setting(s);
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        drain();

        s = '{24'hffffff, 31'h7fffffff, 31'h0, 31'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000};
        apply_setting(s);
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        send_step(1'b0, 1'b1);
        drain();

        // tiny values: products of negatives truncate toward zero
        s = '{24'h1, 31'h1, 31'h1, 31'h1, 32'hffffffff, 32'h00000001, 32'hffffffff};
        apply_setting(s);
        send_step(1'b1, 1'b0);
        send_step(1'b0, 1'b0);
        drain();

        s = '{RST_DT, RST_SIGMA, RST_RHO, RST_BETA, RST_START, RST_START, RST_START};
        apply_setting(s);
        send_step(1'b1, 1'b0);
        repeat (4) send_step(1'b0, 1'b0);
        send_step(1'b0, 1'b1);
        drain();

        left  = RANDOM_ITEMS;
        phase = 0;
        while (left > 0) begin
            apply_setting(random_setting($urandom_range(0, 4) != 0));
            if (phase == 2)
                hold_req = 1'b1;
            n       = $urandom_range(100, 220);
            n       = (n > left) ? left : n;
            gapless = (phase % 4 == 1);
            sent    = 0;
            while (sent < n) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    if (sent < n) begin
                        send_step(sent == 0 || $urandom_range(0, 15) == 0,
                                  $urandom_range(0, 7) == 0);
                        sent++;
                    end
                end
                if (!gapless) begin
                    burst = $urandom_range(0, 15);
                    if (burst > 0) begin
                        step_ch.valid <= 1'b0;
                        repeat (burst) @(negedge i_clk);
                    end
                end
            end
            drain();
            left -= n;
            phase++;
        end

        if (board.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lorenz_pkg.sv
design/lorenz_in_if.sv
design/lorenz_out_if.sv
design/lorenz_fxmul.sv
design/lorenz_euler_step.sv
design/lorenz_checker.sv
verif/lorenz_step_check_pkg.sv
verif/lorenz_euler_step_test.sv
